// ===== rtl/fpc_pkg.sv =====
// ----------------------------------------------------------------------------
// fpc_pkg
// Shared types and constants of the half/single float format converter.
// ----------------------------------------------------------------------------
`default_nettype none

package fpc_pkg;

  localparam int unsigned OpWidth   = 32;
  localparam int unsigned HalfWidth = 16;
  localparam int unsigned IncWidth  = 11;
  localparam int unsigned ShWidth   = 4;

  localparam logic KindH2s = 1'b0;
  localparam logic KindS2h = 1'b1;

  localparam logic [4:0]  HalfExpMax  = 5'h1F;
  localparam logic [7:0]  SingExpMax  = 8'hFF;
  localparam logic [7:0]  SingOvfExp  = 8'd143;
  localparam logic [7:0]  SingSubExp  = 8'd112;
  localparam logic [7:0]  SingTinyExp = 8'd102;
  localparam logic [7:0]  SubShiftRef = 8'd126;
  localparam logic [7:0]  HalfRebias  = 8'd112;
  localparam logic [7:0]  HalfSubBase = 8'd113;
  localparam logic [23:0] RoundHalf   = 24'h001000;

  typedef enum logic [2:0] {
    ClsZero = 3'd0,
    ClsSub  = 3'd1,
    ClsNorm = 3'd2,
    ClsSpec = 3'd3,
    ClsOvf  = 3'd4
  } cls_e;

  typedef struct packed {
    logic                 kind;
    logic                 sign;
    cls_e                 cls;
    logic [ShWidth-1:0]   shift;
    logic [OpWidth-1:0]   operand;
  } dec_t;

  typedef struct packed {
    logic [OpWidth-1:0]   base;
    logic [IncWidth-1:0]  inc;
    logic                 rnd;
  } part_t;

endpackage

`default_nettype wire

// ===== rtl/fpc_if.sv =====
// ----------------------------------------------------------------------------
// fpc_in_if / fpc_out_if
// Valid/ready channels of the format converter: operand in, result out.
// ----------------------------------------------------------------------------
`default_nettype none

interface fpc_in_if;
  logic                           valid;
  logic                           ready;
  logic                           kind;
  logic [fpc_pkg::OpWidth-1:0]    operand;

  modport source (output valid, output kind, output operand, input ready);
  modport sink   (input valid, input kind, input operand, output ready);
endinterface

interface fpc_out_if;
  logic                           valid;
  logic                           ready;
  logic [fpc_pkg::OpWidth-1:0]    converted;

  modport source (output valid, output converted, input ready);
  modport sink   (input valid, input converted, output ready);
endinterface

`default_nettype wire

// ===== rtl/fpc_decode.sv =====
// ----------------------------------------------------------------------------
// fpc_decode
// Classifies the operand and finds the normalize shift of a half subnormal.
// ----------------------------------------------------------------------------
`default_nettype none

module fpc_decode (
  input  wire logic                          kind_i,
  input  wire logic [fpc_pkg::OpWidth-1:0]   operand_i,
  output fpc_pkg::dec_t                      dec_o
);

  logic [4:0]                      h_exp;
  logic [9:0]                      h_man;
  logic [7:0]                      s_exp;
  logic [fpc_pkg::ShWidth-1:0]     lz;
  fpc_pkg::cls_e                   cls;

  assign h_exp = operand_i[14:10];
  assign h_man = operand_i[9:0];
  assign s_exp = operand_i[30:23];

  // highest set bit wins
  always_comb begin
    lz = '0;
    for (int i = 0; i < 10; i++) begin
      if (h_man[i]) begin
        lz = fpc_pkg::ShWidth'(10 - i);
      end
    end
  end

  always_comb begin
    if (kind_i == fpc_pkg::KindH2s) begin
      if (h_exp == 5'd0) begin
        cls = (h_man == 10'd0) ? fpc_pkg::ClsZero : fpc_pkg::ClsSub;
      end else if (h_exp == fpc_pkg::HalfExpMax) begin
        cls = fpc_pkg::ClsSpec;
      end else begin
        cls = fpc_pkg::ClsNorm;
      end
    end else begin
      if (s_exp == fpc_pkg::SingExpMax) begin
        cls = fpc_pkg::ClsSpec;
      end else if (s_exp >= fpc_pkg::SingOvfExp) begin
        cls = fpc_pkg::ClsOvf;
      end else if (s_exp < fpc_pkg::SingTinyExp) begin
        cls = fpc_pkg::ClsZero;
      end else if (s_exp <= fpc_pkg::SingSubExp) begin
        cls = fpc_pkg::ClsSub;
      end else begin
        cls = fpc_pkg::ClsNorm;
      end
    end
  end

  assign dec_o.kind    = kind_i;
  assign dec_o.sign    = (kind_i == fpc_pkg::KindH2s) ? operand_i[15] : operand_i[31];
  assign dec_o.cls     = cls;
  assign dec_o.shift   = lz;
  assign dec_o.operand = operand_i;

endmodule

`default_nettype wire

// ===== rtl/fp16_fp32_converter.sv =====
// ----------------------------------------------------------------------------
// fp16_fp32_converter
// Converts one bit pattern per beat between IEEE binary16 and binary32.
// ----------------------------------------------------------------------------
// Usage:
//   in_i  carries kind (0 = half to single, 1 = single to half) and a 32-bit
//         operand; a half operand uses only bits 15..0.
//   out_o carries the 32-bit converted pattern; a half result sits in
//         bits 15..0 with the upper bits zero.
//   An accepted input beat passes three registered stages on its way to out_o.valid:
//   decode, shift/round, final add into the output register.
//   Throughput is one beat per cycle while out_o.ready stays high; every stage holds its own valid bit.
//   When out_o.ready is low, stages fill up behind the output register and
//   in_i.ready drops only once all three stages hold a beat; nothing is lost
//   or repeated.
//   Reset clears all valid bits; the block takes a beat in the first cycle
//   after reset is released.
// ----------------------------------------------------------------------------
`default_nettype none

module fp16_fp32_converter (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  fpc_in_if.sink      in_i,
  fpc_out_if.source   out_o
);

  fpc_pkg::dec_t                  dec;
  fpc_pkg::dec_t                  s1_q;
  fpc_pkg::part_t                 s2_d, s2_q;
  logic [fpc_pkg::OpWidth-1:0]    s3_d, s3_q;
  logic                           v1_q, v2_q, v3_q;
  logic                           en1, en2, en3;

  assign en3 = !v3_q || out_o.ready;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign in_i.ready = en1;

  fpc_decode u_decode (
    .kind_i    (in_i.kind),
    .operand_i (in_i.operand),
    .dec_o     (dec)
  );

  // shift and round
  logic [4:0]   h_exp;
  logic [9:0]   h_man;
  logic [9:0]   h_norm;
  logic [7:0]   s_exp;
  logic [22:0]  s_man;
  logic [23:0]  s_full;
  logic [4:0]   sub_sh;
  logic [4:0]   rnd_idx;
  logic [23:0]  sub_val;
  logic [23:0]  norm_sum;

  assign h_exp    = s1_q.operand[14:10];
  assign h_man    = s1_q.operand[9:0];
  assign h_norm   = h_man << s1_q.shift;
  assign s_exp    = s1_q.operand[30:23];
  assign s_man    = s1_q.operand[22:0];
  assign s_full   = {1'b1, s_man};
  assign sub_sh   = 5'(fpc_pkg::SubShiftRef - s_exp);
  assign rnd_idx  = 5'(sub_sh - 5'd1);
  assign sub_val  = s_full >> sub_sh;
  assign norm_sum = {1'b0, s_man} + fpc_pkg::RoundHalf;

  always_comb begin
    s2_d = '{base: '0, inc: '0, rnd: 1'b0};
    if (s1_q.kind == fpc_pkg::KindH2s) begin
      case (s1_q.cls)
        fpc_pkg::ClsSub: begin
          s2_d.base = {s1_q.sign,
                       8'(fpc_pkg::HalfSubBase - {4'd0, s1_q.shift}),
                       h_norm, 13'd0};
        end
        fpc_pkg::ClsSpec: begin
          s2_d.base = {s1_q.sign, fpc_pkg::SingExpMax, h_man, 13'd0};
        end
        fpc_pkg::ClsNorm: begin
          s2_d.base = {s1_q.sign, 8'({3'd0, h_exp} + fpc_pkg::HalfRebias),
                       h_man, 13'd0};
        end
        default: begin
          s2_d.base = {s1_q.sign, 31'd0};
        end
      endcase
    end else begin
      case (s1_q.cls)
        fpc_pkg::ClsSpec: begin
          s2_d.base = {16'd0, s1_q.sign, fpc_pkg::HalfExpMax, (s_man != 23'd0), 9'd0};
        end
        fpc_pkg::ClsOvf: begin
          s2_d.base = {16'd0, s1_q.sign, fpc_pkg::HalfExpMax, 10'd0};
        end
        fpc_pkg::ClsSub: begin
          s2_d.base = {16'd0, s1_q.sign, 15'd0};
          s2_d.inc  = sub_val[10:0];
          s2_d.rnd  = s_full[rnd_idx];
        end
        fpc_pkg::ClsNorm: begin
          s2_d.base = {16'd0, s1_q.sign, 5'(s_exp - fpc_pkg::HalfRebias), 10'd0};
          s2_d.inc  = norm_sum[23:13];
        end
        default: begin
          s2_d.base = {16'd0, s1_q.sign, 15'd0};
        end
      endcase
    end
  end

  // a rounding carry runs into the exponent through the add
  assign s3_d = s2_q.base
              + {{(fpc_pkg::OpWidth - fpc_pkg::IncWidth){1'b0}}, s2_q.inc}
              + {{(fpc_pkg::OpWidth - 1){1'b0}}, s2_q.rnd};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_i.valid;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) s1_q <= dec;
    if (en2) s2_q <= s2_d;
    if (en3) s3_q <= s3_d;
  end

  assign out_o.valid     = v3_q;
  assign out_o.converted = s3_q;

endmodule

`default_nettype wire
